>>> rtl/core/sts_pkg.sv
// ============================================================================
// sts_pkg - section timing statistics package
// Shared constants, register map and controller state codes.
// ============================================================================
`default_nettype none

package sts_pkg;

  // Parameter defaults
  localparam int WINDOW_LEN_DEF    = 16;
  localparam int SECTION_COUNT_DEF = 8;

  // Request commands
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Register map (word index)
  localparam logic REG_FRAME_SECTION    = 1'b0;
  localparam logic REG_FRAME_CLEAR_MASK = 1'b1;

  // Register reset values
  localparam logic [2:0] FRAME_SECTION_RST    = 3'd0;
  localparam logic [7:0] FRAME_CLEAR_MASK_RST = 8'd30;

  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RING = 4'b0100,
    ST_DIV  = 4'b1000
  } sts_state_t;

endpackage

`default_nettype wire

>>> rtl/core/section_timing_statistics_core.sv
// ============================================================================
// section_timing_statistics_core - per-section timing statistics
// Event count, last/min/max duration and a moving-window average for each
// numbered section, kept in a statistics memory and a duration ring memory.
// ============================================================================
// A request is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle with out_valid, and the
// receiver cannot stall it. A request naming a section at or above
// SECTION_COUNT is answered at once: the result follows in the next cycle
// with out_ignored set and busy never rises. SUMW = 32 + clog2(WINDOW_LEN)
// is the window sum width. The statistics memory is read in the load
// state, an add then reads the ring entry that leaves the window in the
// ring state, and the bit-serial divider that forms the average from the
// SUMW-bit sum retires one quotient bit per cycle. A start request naming the
// frame section clears the sections selected by the clear mask at once,
// before its own section is read. No clearing pass is needed after reset.
`default_nettype none

module section_timing_statistics_core
  import sts_pkg::*;
#(
  parameter int WINDOW_LEN    = WINDOW_LEN_DEF,
  parameter int SECTION_COUNT = SECTION_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [3:0]  in_section,
  input  wire logic [31:0] in_duration,
  // result channel
  output logic             out_valid,
  output logic             out_ignored,
  output logic [31:0]      out_last_time,
  output logic [31:0]      out_min_time,
  output logic [31:0]      out_max_time,
  output logic [31:0]      out_avg_time,
  output logic [31:0]      out_event_count
);

  localparam int SW    = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int PW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FW    = $clog2(WINDOW_LEN + 1);
  localparam int SUMW  = 32 + $clog2(WINDOW_LEN);
  localparam int RDEP  = SECTION_COUNT * WINDOW_LEN;
  localparam int RW    = (RDEP > 1) ? $clog2(RDEP) : 1;
  localparam int CW    = $clog2(SUMW);
  localparam int MASKN = (SECTION_COUNT < 8) ? SECTION_COUNT : 8;

  typedef struct packed {
    logic [SUMW-1:0] sum;
    logic [PW-1:0]   pos;
    logic [FW-1:0]   fill;
    logic [31:0]     cnt;
    logic [31:0]     last;
    logic [31:0]     min_v;
    logic [31:0]     max_v;
  } stat_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0] frame_section_r;
  logic [7:0] frame_clear_mask_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_section_r    <= FRAME_SECTION_RST;
      frame_clear_mask_r <= FRAME_CLEAR_MASK_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAME_SECTION) begin
        frame_section_r <= pwdata[2:0];
      end else begin
        frame_clear_mask_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_FRAME_SECTION) begin
      prdata = {29'd0, frame_section_r};
    end else begin
      prdata = {24'd0, frame_clear_mask_r};
    end
  end

  // --------------------------------------------------------------------------
  // Controller registers
  // --------------------------------------------------------------------------
  sts_state_t             state_r, state_nxt;
  logic [SECTION_COUNT-1:0] valid_r, valid_nxt;
  logic                   cmd_r;
  logic [SW-1:0]          sec_r;
  logic [31:0]            dur_r;
  logic [RW-1:0]          ring_addr_r, ring_addr_nxt;

  // working copy of the result, divider state
  logic [31:0]            wk_cnt_r, wk_last_r, wk_min_r, wk_max_r;
  logic [31:0]            wk_cnt_nxt, wk_last_nxt, wk_min_nxt, wk_max_nxt;
  logic [FW-1:0]          div_den_r, div_den_nxt;
  logic [FW-1:0]          div_rem_r, div_rem_nxt;
  logic [SUMW-1:0]        div_q_r, div_q_nxt;
  logic [CW-1:0]          div_cnt_r, div_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_ignored_r, out_ignored_nxt;
  logic [31:0]            out_last_r, out_last_nxt;
  logic [31:0]            out_min_r, out_min_nxt;
  logic [31:0]            out_max_r, out_max_nxt;
  logic [31:0]            out_avg_r, out_avg_nxt;
  logic [31:0]            out_cnt_r, out_cnt_nxt;

  // --------------------------------------------------------------------------
  // Memories: statistics per section, duration ring per section
  // --------------------------------------------------------------------------
  stat_t         stat_mem [SECTION_COUNT];
  stat_t         stat_rd_r;
  logic [SW-1:0] stat_raddr;
  logic          stat_we;
  stat_t         stat_wdata;

  logic [31:0]   ring_mem [RDEP];
  logic [31:0]   ring_rd_r;
  logic          ring_we;

  // keep reading the taken section while a request is in flight
  assign stat_raddr = busy ? sec_r : in_section[SW-1:0];

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[sec_r] <= stat_wdata;
    end
    stat_rd_r <= stat_mem[stat_raddr];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_addr_r] <= dur_r;
    end
    ring_rd_r <= ring_mem[ring_addr_nxt];
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic accept;
  logic in_range;
  logic frame_start;

  assign busy        = (state_r != ST_IDLE);
  assign accept      = start && !busy;
  assign in_range    = ({1'b0, in_section} < 5'(SECTION_COUNT));
  assign frame_start = (in_command == CMD_START) && (in_section == {1'b0, frame_section_r});

  // statistics as seen: a cleared or never-written section reads empty
  stat_t cur;
  always_comb begin
    if (valid_r[sec_r]) begin
      cur = stat_rd_r;
    end else begin
      cur.sum   = '0;
      cur.pos   = '0;
      cur.fill  = '0;
      cur.cnt   = '0;
      cur.last  = '0;
      cur.min_v = ALL_ONES32;
      cur.max_v = '0;
    end
  end

  // record one duration into the current statistics
  logic            win_full;
  logic [SUMW-1:0] sum_base;
  always_comb begin
    win_full            = (cur.fill == FW'(WINDOW_LEN));
    sum_base            = win_full ? (cur.sum - SUMW'(ring_rd_r)) : cur.sum;
    stat_wdata.sum      = sum_base + SUMW'(dur_r);
    stat_wdata.pos      = (cur.pos == PW'(WINDOW_LEN - 1)) ? '0 : cur.pos + PW'(1);
    stat_wdata.fill     = win_full ? cur.fill : cur.fill + FW'(1);
    stat_wdata.cnt      = (cur.cnt == ALL_ONES32) ? cur.cnt : cur.cnt + 32'd1;
    stat_wdata.last     = dur_r;
    stat_wdata.min_v    = (dur_r < cur.min_v) ? dur_r : cur.min_v;
    stat_wdata.max_v    = (dur_r > cur.max_v) ? dur_r : cur.max_v;
  end

  // one restoring divide step
  logic [FW:0] div_trial;
  logic        div_ge;
  assign div_trial = {div_rem_r, div_q_r[SUMW-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den_r});

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    ring_addr_nxt   = RW'(RW'(sec_r) * RW'(WINDOW_LEN)) + RW'(cur.pos);
    wk_cnt_nxt      = wk_cnt_r;
    wk_last_nxt     = wk_last_r;
    wk_min_nxt      = wk_min_r;
    wk_max_nxt      = wk_max_r;
    div_den_nxt     = div_den_r;
    div_rem_nxt     = div_rem_r;
    div_q_nxt       = div_q_r;
    div_cnt_nxt     = div_cnt_r;
    stat_we         = 1'b0;
    ring_we         = 1'b0;
    out_valid_nxt   = 1'b0;
    out_ignored_nxt = out_ignored_r;
    out_last_nxt    = out_last_r;
    out_min_nxt     = out_min_r;
    out_max_nxt     = out_max_r;
    out_avg_nxt     = out_avg_r;
    out_cnt_nxt     = out_cnt_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_range) begin
            // out-of-range section: empty fields, no state change
            out_valid_nxt   = 1'b1;
            out_ignored_nxt = 1'b1;
            out_last_nxt    = '0;
            out_min_nxt     = ALL_ONES32;
            out_max_nxt     = '0;
            out_avg_nxt     = '0;
            out_cnt_nxt     = '0;
          end else begin
            if (frame_start) begin
              for (int k = 0; k < MASKN; k++) begin
                if (frame_clear_mask_r[k]) begin
                  valid_nxt[k] = 1'b0;
                end
              end
            end
            state_nxt = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        // statistics read is back; an add goes on to fetch the old ring entry
        if (cmd_r == CMD_ADD) begin
          state_nxt = ST_RING;
        end else begin
          wk_cnt_nxt  = cur.cnt;
          wk_last_nxt = cur.last;
          wk_min_nxt  = cur.min_v;
          wk_max_nxt  = cur.max_v;
          div_den_nxt = cur.fill;
          div_rem_nxt = '0;
          div_q_nxt   = cur.sum;
          div_cnt_nxt = CW'(SUMW - 1);
          state_nxt   = ST_DIV;
        end
      end

      ST_RING: begin
        // write back the updated statistics and the new ring entry
        ring_addr_nxt      = ring_addr_r;
        stat_we            = 1'b1;
        ring_we            = 1'b1;
        valid_nxt[sec_r]   = 1'b1;
        wk_cnt_nxt         = stat_wdata.cnt;
        wk_last_nxt        = stat_wdata.last;
        wk_min_nxt         = stat_wdata.min_v;
        wk_max_nxt         = stat_wdata.max_v;
        div_den_nxt        = stat_wdata.fill;
        div_rem_nxt        = '0;
        div_q_nxt          = stat_wdata.sum;
        div_cnt_nxt        = CW'(SUMW - 1);
        state_nxt          = ST_DIV;
      end

      ST_DIV: begin
        // one quotient bit per cycle
        ring_addr_nxt = ring_addr_r;
        div_rem_nxt   = div_ge ? FW'(div_trial - {1'b0, div_den_r}) : div_trial[FW-1:0];
        div_q_nxt     = {div_q_r[SUMW-2:0], div_ge};
        div_cnt_nxt   = div_cnt_r - CW'(1);
        if (div_cnt_r == '0) begin
          out_valid_nxt   = 1'b1;
          out_ignored_nxt = 1'b0;
          out_last_nxt    = wk_last_r;
          out_min_nxt     = wk_min_r;
          out_max_nxt     = wk_max_r;
          out_cnt_nxt     = wk_cnt_r;
          out_avg_nxt     = (div_den_r == '0) ? 32'd0 : div_q_nxt[31:0];
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      sec_r <= in_section[SW-1:0];
      dur_r <= in_duration;
    end
    ring_addr_r   <= ring_addr_nxt;
    wk_cnt_r      <= wk_cnt_nxt;
    wk_last_r     <= wk_last_nxt;
    wk_min_r      <= wk_min_nxt;
    wk_max_r      <= wk_max_nxt;
    div_den_r     <= div_den_nxt;
    div_rem_r     <= div_rem_nxt;
    div_q_r       <= div_q_nxt;
    div_cnt_r     <= div_cnt_nxt;
    out_ignored_r <= out_ignored_nxt;
    out_last_r    <= out_last_nxt;
    out_min_r     <= out_min_nxt;
    out_max_r     <= out_max_nxt;
    out_avg_r     <= out_avg_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ignored     = out_ignored_r;
  assign out_last_time   = out_last_r;
  assign out_min_time    = out_min_r;
  assign out_max_time    = out_max_r;
  assign out_avg_time    = out_avg_r;
  assign out_event_count = out_cnt_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a result only follows a finished divide or a taken request
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_DIV) || $past(start && !busy))
    else $error("result without a request");

  // busy only rises after a request was taken
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // the divisor is a window fill and never exceeds the window length
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ({1'b0, div_den_r} <= (FW + 1)'(WINDOW_LEN)))
    else $error("window fill out of range");

  // an ignored request reports an empty section
  a_ignored_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ignored) |->
      (out_event_count == '0) && (out_min_time == ALL_ONES32) && (out_avg_time == '0))
    else $error("ignored request reported statistics");

endmodule

`default_nettype wire
